// ===== design/pbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbe_pkg
// Shared types and constants for the PackBits row encoder.
// ----------------------------------------------------------------------------
package pbe_pkg;

    localparam int MAX_CHUNK = 128;
    localparam int LIT_AW    = $clog2(MAX_CHUNK);

    // one queued command: close run A, at row end also run B; raw passes B
    typedef struct packed {
        logic       raw;     // pass b_byte through unchanged
        logic       last;    // row ends with this command
        logic [7:0] a_byte;
        logic [7:0] a_len;   // 0 = nothing to close
        logic [7:0] b_byte;
        logic [7:0] b_len;
    } t_cmd;

    // one result word
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  cnt;
        logic        done;
        logic [15:0] len;
    } t_word;

    // byte stream from the engine to the word packer
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data;
        logic       finish;
        logic       idle;
    } t_pack_req;

endpackage

// ===== design/pbe_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbe_fifo
// Small register queue, power-of-two depth.
// ----------------------------------------------------------------------------
module pbe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             wr_ok, rd_ok;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign wr_ok   = i_wr & ~o_full;
    assign rd_ok   = i_rd & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) r_wp <= r_wp + 1'b1;
            if (rd_ok) r_rp <= r_rp + 1'b1;
            if (wr_ok && !rd_ok)      r_cnt <= r_cnt + 1'b1;
            else if (!wr_ok && rd_ok) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) r_mem[r_wp] <= i_wdata;
    end
endmodule

// ===== design/pbe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbe_front
// Accepts row bytes, tracks the open run and queues close or raw commands.
// ----------------------------------------------------------------------------
module pbe_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_data,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_row_end,
    output logic             o_cmd_push,
    output pbe_pkg::t_cmd    o_cmd
);
    logic       r_compress, r_started;
    logic [7:0] r_run_byte, r_run_len;
    logic [7:0] n_run_byte, n_run_len, a_len;
    logic       extend;

    assign extend = r_started && (i_data_byte == r_run_byte)
                    && (r_run_len < 8'(pbe_pkg::MAX_CHUNK));

    always_comb begin
        a_len      = '0;
        n_run_byte = i_data_byte;
        n_run_len  = 8'd1;
        if (extend) begin
            n_run_byte = r_run_byte;
            n_run_len  = r_run_len + 8'd1;
        end else if (r_started) begin
            a_len = r_run_len;
        end
    end

    always_comb begin
        o_cmd.raw    = ~r_compress;
        o_cmd.last   = i_row_end;
        o_cmd.a_byte = r_run_byte;
        o_cmd.a_len  = r_compress ? a_len : 8'd0;
        o_cmd.b_byte = r_compress ? n_run_byte : i_data_byte;
        o_cmd.b_len  = n_run_len;
        o_cmd_push   = i_accept & (~r_compress | i_row_end | (a_len != 8'd0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compress <= 1'b1;
            r_started  <= 1'b0;
            r_run_byte <= '0;
            r_run_len  <= '0;
        end else begin
            // mode is frozen while a row is open
            if (i_cfg_we && !r_started) r_compress <= i_cfg_data;
            if (i_accept) begin
                r_started <= ~i_row_end;
                if (i_row_end || !r_compress) begin
                    r_run_len <= '0;
                end else begin
                    r_run_byte <= n_run_byte;
                    r_run_len  <= n_run_len;
                end
            end
        end
    end
endmodule

// ===== design/pbe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbe_back
// Executes queued commands: literal store, chunk flushes, run output and raw
// bytes, one encoded byte per cycle toward the packer while it is ready.
// ----------------------------------------------------------------------------
module pbe_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_empty,
    input  pbe_pkg::t_cmd         i_cmd,
    output logic                  o_cmd_pop,
    output pbe_pkg::t_pack_req    o_req,
    input  logic                  i_byte_ready,
    input  logic                  i_fin_ready
);
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CLOSE   = 3'd1;
    localparam logic [2:0] S_RUNHDR  = 3'd2;
    localparam logic [2:0] S_RUNBYTE = 3'd3;
    localparam logic [2:0] S_FHDR    = 3'd4;
    localparam logic [2:0] S_FDATA   = 3'd5;
    localparam logic [2:0] S_RAW     = 3'd6;
    localparam logic [2:0] S_FIN     = 3'd7;

    localparam int AW = pbe_pkg::LIT_AW;

    logic [2:0]    r_state, n_state, r_ret, n_ret;
    pbe_pkg::t_cmd r_cmd;
    logic          r_phase, n_phase;
    logic [7:0]    r_cur_byte, n_cur_byte, r_cur_len, n_cur_len;
    logic [7:0]    r_lit_cnt, n_lit_cnt;
    logic [AW-1:0] r_idx, n_idx, rd_addr;
    logic [7:0]    r_mem [pbe_pkg::MAX_CHUNK];
    logic [7:0]    r_rd_data;
    logic          emit_ok, lit_wr;

    always_comb begin
        o_req.byte_valid = 1'b0;
        o_req.data       = r_cur_byte;
        unique case (r_state)
            S_RUNHDR:  begin
                o_req.byte_valid = 1'b1;
                o_req.data = 8'(9'h101 - {1'b0, r_cur_len});
            end
            S_RUNBYTE: o_req.byte_valid = 1'b1;
            S_FHDR:    begin
                o_req.byte_valid = 1'b1;
                o_req.data = r_lit_cnt - 8'd1;
            end
            S_FDATA:   begin
                o_req.byte_valid = 1'b1;
                o_req.data = r_rd_data;
            end
            S_RAW:     begin
                o_req.byte_valid = 1'b1;
                o_req.data = r_cmd.b_byte;
            end
            default:   o_req.byte_valid = 1'b0;
        endcase
        o_req.finish = (r_state == S_FIN);
        o_req.idle   = (r_state == S_IDLE);
    end

    assign emit_ok   = o_req.byte_valid & i_byte_ready;
    assign o_cmd_pop = (r_state == S_IDLE) & ~i_cmd_empty;
    assign lit_wr    = (r_state == S_CLOSE) && (r_cur_len != 8'd0) && (r_cur_len <= 8'd2);
    // prefetch next literal while the current one goes out
    assign rd_addr   = (r_state == S_FDATA) ? (emit_ok ? r_idx + 1'b1 : r_idx) : '0;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_phase    = r_phase;
        n_cur_byte = r_cur_byte;
        n_cur_len  = r_cur_len;
        n_lit_cnt  = r_lit_cnt;
        n_idx      = r_idx;
        unique case (r_state)
            S_IDLE: if (!i_cmd_empty) begin
                n_cur_byte = i_cmd.a_byte;
                n_cur_len  = i_cmd.a_len;
                n_phase    = 1'b0;
                n_state    = i_cmd.raw ? S_RAW : S_CLOSE;
            end
            S_CLOSE: begin
                if (r_cur_len == 8'd0) begin
                    if (!r_phase) begin
                        if (r_cmd.last) begin
                            n_phase    = 1'b1;
                            n_cur_byte = r_cmd.b_byte;
                            n_cur_len  = r_cmd.b_len;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_ret   = S_FIN;
                        n_state = (r_lit_cnt != 8'd0) ? S_FHDR : S_FIN;
                    end
                end else if (r_cur_len > 8'd2) begin
                    n_ret   = S_RUNHDR;
                    n_state = (r_lit_cnt != 8'd0) ? S_FHDR : S_RUNHDR;
                end else begin
                    n_lit_cnt = r_lit_cnt + 8'd1;
                    n_cur_len = r_cur_len - 8'd1;
                    if (n_lit_cnt == 8'(pbe_pkg::MAX_CHUNK)) begin
                        n_ret   = S_CLOSE;
                        n_state = S_FHDR;
                    end
                end
            end
            S_RUNHDR:  if (emit_ok) n_state = S_RUNBYTE;
            S_RUNBYTE: if (emit_ok) begin
                n_cur_len = '0;
                n_state   = S_CLOSE;
            end
            S_FHDR: if (emit_ok) begin
                n_idx   = '0;
                n_state = S_FDATA;
            end
            S_FDATA: if (emit_ok) begin
                n_idx = r_idx + 1'b1;
                if ({1'b0, r_idx} == r_lit_cnt - 8'd1) begin
                    n_lit_cnt = '0;
                    n_state   = r_ret;
                end
            end
            S_RAW: if (emit_ok) n_state = r_cmd.last ? S_FIN : S_IDLE;
            S_FIN: if (i_fin_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_phase   <= 1'b0;
            r_lit_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_phase   <= n_phase;
            r_lit_cnt <= n_lit_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_byte <= n_cur_byte;
        r_cur_len  <= n_cur_len;
        r_idx      <= n_idx;
        if (o_cmd_pop) r_cmd <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (lit_wr) r_mem[r_lit_cnt[AW-1:0]] <= r_cur_byte;
        r_rd_data <= r_mem[rd_addr];
    end
endmodule

// ===== design/pbe_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbe_pack
// Packs encoded bytes into 64-bit words and counts the row length.
// ----------------------------------------------------------------------------
module pbe_pack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pbe_pkg::t_pack_req i_req,
    output logic               o_byte_ready,
    output logic               o_fin_ready,
    input  logic               i_out_full,
    output logic               o_push,
    output pbe_pkg::t_word     o_word
);
    logic [63:0] r_word, n_word;
    logic [3:0]  r_fill, n_fill;
    logic [15:0] r_count, n_count;
    logic        full_word;

    assign full_word    = (r_fill == 4'd8);
    assign o_byte_ready = ~full_word | ~i_out_full;
    assign o_fin_ready  = ~i_out_full;

    always_comb begin
        o_push      = 1'b0;
        o_word.word = r_word;
        o_word.cnt  = r_fill;
        o_word.done = 1'b0;
        o_word.len  = '0;
        n_word      = r_word;
        n_fill      = r_fill;
        n_count     = r_count;
        if (i_req.finish) begin
            if (!i_out_full) begin
                o_push      = 1'b1;
                o_word.done = 1'b1;
                o_word.len  = r_count;
                n_word      = '0;
                n_fill      = '0;
                n_count     = '0;
            end
        end else if (i_req.byte_valid) begin
            if (o_byte_ready) begin
                if (r_count != 16'hFFFF) n_count = r_count + 16'd1;
                if (full_word) begin
                    o_push = 1'b1;
                    n_word = 64'(i_req.data);
                    n_fill = 4'd1;
                end else begin
                    n_word = r_word | (64'(i_req.data) << {r_fill[2:0], 3'b000});
                    n_fill = r_fill + 4'd1;
                end
            end
        end else if (i_req.idle && full_word && !i_out_full) begin
            // engine is between commands: this full word cannot be the row's last
            o_push = 1'b1;
            n_word = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word  <= '0;
            r_fill  <= '0;
            r_count <= '0;
        end else begin
            r_word  <= n_word;
            r_fill  <= n_fill;
            r_count <= n_count;
        end
    end
endmodule

// ===== design/packbits_row_encoder_unit.sv =====
`timescale 1ns / 1ps
// Throughput: the front takes one byte per cycle while the 4-entry command queue has
// room; the back takes one command at a time, from idle through raw, or through close,
// run header, run byte and literal flush states, so it can fall behind the input, and
// the back end stalls push through full.
// Reset: synchronous active-low; clears queues, run state and sets compress on.
// ----------------------------------------------------------------------------
// packbits_row_encoder_unit
// PackBits row encoder with raw pass-through and 64-bit output word packing.
// ----------------------------------------------------------------------------
module packbits_row_encoder_unit #(
    parameter int CMD_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_row_end,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_out_word,
    output logic [3:0]  o_byte_count,
    output logic        o_row_done,
    output logic [15:0] o_row_length
);
    localparam int CW = $bits(pbe_pkg::t_cmd);
    localparam int OW = $bits(pbe_pkg::t_word);

    pbe_pkg::t_cmd      fe_cmd;
    logic               fe_push, cmd_empty, cmd_pop;
    logic [CW-1:0]      cmd_q;
    pbe_pkg::t_pack_req req;
    logic               byte_ready, fin_ready, out_full, out_push;
    pbe_pkg::t_word     pk_word, out_word;
    logic [OW-1:0]      out_q;

    pbe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (push & ~full),
        .i_data_byte (i_data_byte),
        .i_row_end   (i_row_end),
        .o_cmd_push  (fe_push),
        .o_cmd       (fe_cmd)
    );

    pbe_fifo #(.WIDTH(CW), .DEPTH(CMD_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fe_push),
        .i_wdata (fe_cmd),
        .o_full  (full),
        .i_rd    (cmd_pop),
        .o_rdata (cmd_q),
        .o_empty (cmd_empty)
    );

    pbe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_empty  (cmd_empty),
        .i_cmd        (pbe_pkg::t_cmd'(cmd_q)),
        .o_cmd_pop    (cmd_pop),
        .o_req        (req),
        .i_byte_ready (byte_ready),
        .i_fin_ready  (fin_ready)
    );

    pbe_pack u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .o_byte_ready (byte_ready),
        .o_fin_ready  (fin_ready),
        .i_out_full   (out_full),
        .o_push       (out_push),
        .o_word       (pk_word)
    );

    pbe_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (out_push),
        .i_wdata (pk_word),
        .o_full  (out_full),
        .i_rd    (pop),
        .o_rdata (out_q),
        .o_empty (empty)
    );

    assign out_word     = pbe_pkg::t_word'(out_q);
    assign o_out_word   = out_word.word;
    assign o_byte_count = out_word.cnt;
    assign o_row_done   = out_word.done;
    assign o_row_length = out_word.len;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_byte_count != 4'd0 && o_byte_count <= 4'd8))
        else $error("byte_count out of range");
    a_mid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_row_done) |-> (o_byte_count == 4'd8 && o_row_length == 16'd0))
        else $error("partial or tagged word before row end");
    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_row_done) |-> (o_row_length != 16'd0))
        else $error("finished row with zero length");
`endif
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for packbits_row_encoder_unit: rows of bytes are
// pushed in PackBits and raw modes under varied push/pop gaps. A local
// encoder and packer predict every output word, which is checked field by
// field.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_data;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_row_end;
    logic        empty;
    logic        pop;
    logic [63:0] o_out_word;
    logic [3:0]  o_byte_count;
    logic        o_row_done;
    logic [15:0] o_row_length;

    packbits_row_encoder_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .i_row_end   (i_row_end),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word),
        .o_byte_count(o_byte_count),
        .o_row_done  (o_row_done),
        .o_row_length(o_row_length)
    );

    typedef struct {
        logic [63:0] word;
        logic [3:0]  cnt;
        logic        done;
        logic [15:0] len;
    } t_out;

    // directed rows: one byte each, expected word typed in on simple rows
    typedef struct {
        logic        mode;
        logic [7:0]  data;
        logic        last;
        logic        has_exp;
        logic [63:0] word;
        logic [3:0]  cnt;
        logic [15:0] len;
    } t_row_byte;

    // encoder state
    logic        pb_compress;
    logic [7:0]  lit_store [130];
    int          lit_cnt;
    logic [7:0]  run_byte;
    int          run_len;
    int unsigned enc_cnt;
    logic        row_open;
    logic [7:0]  pack_q [$];
    t_out        words_due [$];

    int          errors;
    int          words_seen;
    int          items_sent;
    int          rows_sent;
    int          send_idle_pct;
    int          pop_stall_pct;
    int          hold_cycles;
    longint      cycle_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words pending", cycle_cnt, words_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic void emit(input logic [7:0] b);
        pack_q.push_back(b);
        if (enc_cnt < 16'hFFFF) enc_cnt++;
    endfunction

    function automatic void flush_literals();
        if (lit_cnt == 0) return;
        emit(8'(lit_cnt - 1));
        for (int k = 0; k < lit_cnt; k++) emit(lit_store[k]);
        lit_cnt = 0;
    endfunction

    function automatic void add_literal(input logic [7:0] b);
        lit_store[lit_cnt] = b;
        lit_cnt++;
        if (lit_cnt >= pbe_pkg::MAX_CHUNK) flush_literals();
    endfunction

    function automatic void close_run();
        if (run_len > 2) begin
            flush_literals();
            emit(8'(9'h101 - run_len));
            emit(run_byte);
        end else begin
            for (int k = 0; k < run_len; k++) add_literal(run_byte);
        end
        run_len = 0;
    endfunction

    function automatic void packbits_predict(input logic [7:0] b, input logic last);
        int   nwords;
        int   cnt;
        t_out w;
        if (pb_compress) begin
            if (!row_open) begin
                run_byte = b;
                run_len  = 1;
            end else if (b == run_byte && run_len < pbe_pkg::MAX_CHUNK) begin
                run_len++;
            end else begin
                close_run();
                run_byte = b;
                run_len  = 1;
            end
            if (last) begin
                close_run();
                flush_literals();
            end
        end else begin
            emit(b);
        end
        row_open = 1'b1;
        nwords = last ? (pack_q.size() + 7) / 8 : pack_q.size() / 8;
        for (int k = 0; k < nwords; k++) begin
            cnt    = pack_q.size() > 8 ? 8 : pack_q.size();
            w.word = '0;
            for (int j = 0; j < cnt; j++) w.word[8*j +: 8] = pack_q.pop_front();
            w.cnt  = 4'(cnt);
            w.done = last && (k + 1 == nwords);
            w.len  = w.done ? 16'(enc_cnt) : 16'd0;
            words_due.push_back(w);
        end
        if (last) begin
            enc_cnt  = 0;
            lit_cnt  = 0;
            run_len  = 0;
            row_open = 1'b0;
        end
    endfunction

    // ---------------- result side ----------------
    initial begin
        t_out want;
        pop = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                words_seen++;
                if (words_due.size() == 0) begin
                    $display("%0t: unexpected word %h cnt %0d", $realtime, o_out_word, o_byte_count);
                    errors++;
                end else begin
                    want = words_due.pop_front();
                    if (o_out_word !== want.word) begin
                        $display("%0t: out_word exp %h got %h", $realtime, want.word, o_out_word);
                        errors++;
                    end
                    if (o_byte_count !== want.cnt) begin
                        $display("%0t: byte_count exp %0d got %0d", $realtime, want.cnt, o_byte_count);
                        errors++;
                    end
                    if (o_row_done !== want.done) begin
                        $display("%0t: row_done exp %b got %b", $realtime, want.done, o_row_done);
                        errors++;
                    end
                    if (o_row_length !== want.len) begin
                        $display("%0t: row_length exp %0d got %0d", $realtime, want.len, o_row_length);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= pop_stall_pct);
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_data_byte <= b;
        i_row_end   <= last;
        do @(posedge i_clk); while (full);
        packbits_predict(b, last);
        items_sent++;
        if (last) rows_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (!row_open) pb_compress = m;
    endtask

    // rows lean on short runs so both runs and literals show up
    task automatic random_row(input int len);
        logic [7:0] b;
        b = 8'($urandom);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 45) b = 8'($urandom);
            send_byte(b, k == len - 1);
        end
    endtask

    t_row_byte directed [] = '{
        '{1'b1, 8'hAB, 1'b1, 1'b1, 64'h0000_0000_0000_AB00, 4'd2, 16'd2},
        '{1'b1, 8'h00, 1'b0, 1'b0, 64'h0, 4'd0, 16'd0},
        '{1'b1, 8'h00, 1'b0, 1'b0, 64'h0, 4'd0, 16'd0},
        '{1'b1, 8'h00, 1'b1, 1'b1, 64'h0000_0000_0000_00FE, 4'd2, 16'd2},
        '{1'b1, 8'hFF, 1'b0, 1'b0, 64'h0, 4'd0, 16'd0},
        '{1'b1, 8'hFF, 1'b1, 1'b1, 64'h0000_0000_00FF_FF01, 4'd3, 16'd3},
        '{1'b1, 8'h12, 1'b0, 1'b0, 64'h0, 4'd0, 16'd0},
        '{1'b1, 8'h34, 1'b0, 1'b0, 64'h0, 4'd0, 16'd0},
        '{1'b1, 8'h56, 1'b1, 1'b1, 64'h0000_0000_5634_1202, 4'd4, 16'd4},
        '{1'b1, 8'h7F, 1'b0, 1'b0, 64'h0, 4'd0, 16'd0},
        '{1'b1, 8'h80, 1'b0, 1'b0, 64'h0, 4'd0, 16'd0},
        '{1'b1, 8'h80, 1'b0, 1'b0, 64'h0, 4'd0, 16'd0},
        '{1'b1, 8'h80, 1'b0, 1'b0, 64'h0, 4'd0, 16'd0},
        '{1'b1, 8'h01, 1'b1, 1'b0, 64'h0, 4'd0, 16'd0},
        '{1'b0, 8'h80, 1'b1, 1'b1, 64'h0000_0000_0000_0080, 4'd1, 16'd1},
        '{1'b0, 8'h00, 1'b0, 1'b0, 64'h0, 4'd0, 16'd0},
        '{1'b0, 8'hFF, 1'b1, 1'b1, 64'h0000_0000_0000_FF00, 4'd2, 16'd2}
    };

    initial begin
        t_out got;
        int   phase_idle [4];
        int   phase_stall[4];
        phase_idle  = '{0, 73, 0, 19};
        phase_stall = '{0, 0, 73, 19};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 1'b0;
        push = 1'b0;
        i_data_byte = '0;
        i_row_end = 1'b0;
        errors = 0; words_seen = 0; items_sent = 0; rows_sent = 0;
        send_idle_pct = 0; pop_stall_pct = 0; hold_cycles = 0;
        pb_compress = 1'b1; lit_cnt = 0; run_byte = '0; run_len = 0;
        enc_cnt = 0; row_open = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed[i]) begin
            if (directed[i].mode != pb_compress) begin
                drain();
                write_mode(directed[i].mode);
            end
            send_byte(directed[i].data, directed[i].last);
            if (directed[i].has_exp) begin
                got = words_due[$];
                if (got.word !== directed[i].word || got.cnt !== directed[i].cnt
                        || got.len !== directed[i].len || !got.done) begin
                    $display("%0t: table row %0d exp %h/%0d/%0d predicted %h/%0d/%0d",
                             $realtime, i, directed[i].word, directed[i].cnt, directed[i].len,
                             got.word, got.cnt, got.len);
                    errors++;
                end
            end
        end
        drain();

        // phases: literal chunk row, run cap row, short random rows, raw rows
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_idle[p];
            pop_stall_pct = phase_stall[p];
            write_mode(p != 3);
            if (p == 0) begin
                // receiver holds off across the chunk flush while bytes keep coming
                hold_cycles = 600;
                for (int k = 0; k < 134; k++) send_byte(8'(k * 7 + 1), k == 133);
            end else if (p == 1) begin
                // full-length run, then one more equal byte opens a new run
                for (int k = 0; k < 129; k++) send_byte(8'h5A, k == 128);
            end else begin
                for (int n = 0; n < 10; ) begin
                    int len;
                    len = $urandom_range(1, 6);
                    random_row(len);
                    n += len;
                end
            end
            drain();
        end

        $display("Covered %0d bytes in %0d rows, %0d words checked, both modes", items_sent,
                 rows_sent, words_seen);
        $display("Includes run cap, literal chunk flush under output back-pressure, idle phases");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
